// ===== design/float_to_pcm_sample_packer_top_assert.svh =====
// Assertion macros used by the sample packer top level.
`ifndef FLOAT_TO_PCM_SAMPLE_PACKER_TOP_ASSERT_SVH
`define FLOAT_TO_PCM_SAMPLE_PACKER_TOP_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`ifndef SYNTH
`define F2PCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`else
`define F2PCM_ASSERT(lbl, prop, msg)
`endif

// Clocked check that also holds across reset.
`ifndef SYNTH
`define F2PCM_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define F2PCM_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== design/f2pcm_pkg.sv =====
// Types, format codes and format decode for the float32 to PCM sample packer.
package f2pcm_pkg;

    typedef enum logic [1:0] {
        ENC_INT,
        ENC_F32,
        ENC_F64
    } enc_t;

    localparam logic [4:0] FMT_I16_BE     = 5'd0;
    localparam logic [4:0] FMT_I24_BE     = 5'd1;
    localparam logic [4:0] FMT_I32_BE     = 5'd2;
    localparam logic [4:0] FMT_F32_BE     = 5'd3;
    localparam logic [4:0] FMT_F64_BE     = 5'd4;
    localparam logic [4:0] FMT_I32V16_BE  = 5'd5;
    localparam logic [4:0] FMT_I32V18_BE  = 5'd6;
    localparam logic [4:0] FMT_I32V20_BE  = 5'd7;
    localparam logic [4:0] FMT_I32V24_BE  = 5'd8;
    localparam logic [4:0] FMT_I16_LE     = 5'd9;
    localparam logic [4:0] FMT_I24_LE     = 5'd10;
    localparam logic [4:0] FMT_I32_LE     = 5'd11;
    localparam logic [4:0] FMT_F32_LE     = 5'd12;
    localparam logic [4:0] FMT_F64_LE     = 5'd13;
    localparam logic [4:0] FMT_I32V16_LE  = 5'd14;
    localparam logic [4:0] FMT_I32V18_LE  = 5'd15;
    localparam logic [4:0] FMT_I32V20_LE  = 5'd16;
    localparam logic [4:0] FMT_I32V24_LE  = 5'd17;
    localparam logic [4:0] FMT_RESET      = FMT_I16_LE;

    typedef struct packed {
        logic       supported;
        logic [3:0] nbytes;
        logic [5:0] bits;
        enc_t       enc;
        logic       big;
    } fmt_t;

    // Stage 1 -> stage 2 payload.
    typedef struct packed {
        fmt_t        fmt;
        logic [31:0] clamped;
        logic        ge1;
        logic [7:0]  kshift;
        logic [31:0] mant32;
        logic [4:0]  lead_pos;
        logic        is_denorm;
        logic        is_zero;
    } s1_t;

    // Stage 2 -> stage 3 payload.
    typedef struct packed {
        fmt_t        fmt;
        logic [31:0] clamped;
        logic        ge1;
        logic [31:0] whole;
        logic        rnd;
        logic [63:0] f64_bits;
    } s2_t;

    function automatic fmt_t mk(input logic [3:0] n, input logic [5:0] b,
                                input enc_t e, input logic bg);
        fmt_t f;
        f.supported = 1'b1;
        f.nbytes    = n;
        f.bits      = b;
        f.enc       = e;
        f.big       = bg;
        return f;
    endfunction

    function automatic fmt_t fmt_decode(input logic [4:0] code);
        fmt_t f;
        f = '0;
        f.enc = ENC_INT;
        unique case (code)
            FMT_I16_BE:    f = mk(4'd2, 6'd16, ENC_INT, 1'b1);
            FMT_I24_BE:    f = mk(4'd3, 6'd24, ENC_INT, 1'b1);
            FMT_I32_BE:    f = mk(4'd4, 6'd32, ENC_INT, 1'b1);
            FMT_F32_BE:    f = mk(4'd4, 6'd32, ENC_F32, 1'b1);
            FMT_F64_BE:    f = mk(4'd8, 6'd32, ENC_F64, 1'b1);
            FMT_I32V16_BE: f = mk(4'd4, 6'd16, ENC_INT, 1'b1);
            FMT_I32V18_BE: f = mk(4'd4, 6'd18, ENC_INT, 1'b1);
            FMT_I32V20_BE: f = mk(4'd4, 6'd20, ENC_INT, 1'b1);
            FMT_I32V24_BE: f = mk(4'd4, 6'd24, ENC_INT, 1'b1);
            FMT_I16_LE:    f = mk(4'd2, 6'd16, ENC_INT, 1'b0);
            FMT_I24_LE:    f = mk(4'd3, 6'd24, ENC_INT, 1'b0);
            FMT_I32_LE:    f = mk(4'd4, 6'd32, ENC_INT, 1'b0);
            FMT_F32_LE:    f = mk(4'd4, 6'd32, ENC_F32, 1'b0);
            FMT_F64_LE:    f = mk(4'd8, 6'd32, ENC_F64, 1'b0);
            FMT_I32V16_LE: f = mk(4'd4, 6'd16, ENC_INT, 1'b0);
            FMT_I32V18_LE: f = mk(4'd4, 6'd18, ENC_INT, 1'b0);
            FMT_I32V20_LE: f = mk(4'd4, 6'd20, ENC_INT, 1'b0);
            FMT_I32V24_LE: f = mk(4'd4, 6'd24, ENC_INT, 1'b0);
            default:       f.supported = 1'b0;
        endcase
        return f;
    endfunction

endpackage

// ===== design/f2pcm_decode.sv =====
// Stage 1: format decode, NaN and range clamp, shift and leading-one setup.
module f2pcm_decode
    import f2pcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_bits,
    input  logic [4:0]  fmt_code,
    output logic        out_valid,
    input  logic        out_ready,
    output s1_t         out_data
);
    logic        vld_reg, vld_next;
    s1_t         data_reg, data_next;
    logic [7:0]  e_raw, e_eff;
    logic [22:0] m_raw;
    logic [31:0] c;
    logic [8:0]  k9;
    logic [4:0]  pos;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;
    assign vld_next  = in_ready ? in_valid : vld_reg;

    always_comb begin
        e_raw = in_bits[30:23];
        m_raw = in_bits[22:0];
        // NaN maps to +0; anything at or above one in magnitude clamps to one.
        if (e_raw == 8'hFF && m_raw != 23'd0) begin
            c = 32'd0;
        end else if (e_raw >= 8'd127) begin
            c = {in_bits[31], 8'd127, 23'd0};
        end else begin
            c = in_bits;
        end
        e_eff = (c[30:23] == 8'd0) ? 8'd1 : c[30:23];
        pos = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (c[i]) pos = 5'(i);
        end
        data_next.fmt       = fmt_decode(fmt_code);
        k9 = 9'd159 - {1'b0, e_eff} - {3'b0, data_next.fmt.bits};
        data_next.clamped   = c;
        data_next.ge1       = (c[30:23] == 8'd127);
        data_next.kshift    = k9[7:0];
        data_next.mant32    = {(c[30:23] != 8'd0), c[22:0], 8'd0};
        data_next.lead_pos  = pos;
        data_next.is_zero   = (c[30:0] == 31'd0);
        data_next.is_denorm = (c[30:23] == 8'd0) && (c[22:0] != 23'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule

// ===== design/f2pcm_shift.sv =====
// Stage 2: magnitude alignment with round bit, and float64 widening.
module f2pcm_shift
    import f2pcm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  s1_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s2_t  out_data
);
    logic        vld_reg, vld_next;
    s2_t         data_reg, data_next;
    logic [32:0] sh;
    logic [52:0] n53;
    logic [5:0]  nsh;
    logic [10:0] exp11;

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;
    assign vld_next  = in_ready ? in_valid : vld_reg;

    always_comb begin
        sh  = {in_data.mant32, 1'b0} >> in_data.kshift;
        nsh = 6'd52 - {1'b0, in_data.lead_pos};
        n53 = {30'd0, in_data.clamped[22:0]} << nsh;
        if (in_data.is_zero) begin
            exp11 = 11'd0;
            data_next.f64_bits = {in_data.clamped[31], 63'd0};
        end else if (in_data.is_denorm) begin
            exp11 = {6'd0, in_data.lead_pos} + 11'd874;
            data_next.f64_bits = {in_data.clamped[31], exp11, n53[51:0]};
        end else begin
            exp11 = {3'd0, in_data.clamped[30:23]} + 11'd896;
            data_next.f64_bits = {in_data.clamped[31], exp11,
                                  in_data.clamped[22:0], 29'd0};
        end
        data_next.fmt     = in_data.fmt;
        data_next.clamped = in_data.clamped;
        data_next.ge1     = in_data.ge1;
        data_next.whole   = sh[32:1];
        data_next.rnd     = sh[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end
endmodule

// ===== design/f2pcm_pack.sv =====
// Stage 3: rounding, sign, saturation, encoding select and byte ordering.
module f2pcm_pack
    import f2pcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  s2_t         in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_bytes,
    output logic [3:0]  sample_len,
    output logic        status
);
    logic        vld_reg, vld_next;
    logic [63:0] bytes_reg, bytes_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        st_reg, st_next;
    logic [32:0] half, magr, q;
    logic [63:0] v;
    logic        neg;

    assign in_ready   = !vld_reg || out_ready;
    assign out_valid  = vld_reg;
    assign out_bytes  = bytes_reg;
    assign sample_len = cnt_reg;
    assign status     = st_reg;
    assign vld_next   = in_ready ? in_valid : vld_reg;

    always_comb begin
        neg  = in_data.clamped[31];
        half = 33'd1 << (in_data.fmt.bits - 6'd1);
        magr = {1'b0, in_data.whole} + {32'd0, in_data.rnd};
        if (in_data.ge1) begin
            q = neg ? (33'd0 - half) : (half - 33'd1);
        end else if (!neg && magr >= half) begin
            q = half - 33'd1;
        end else begin
            q = neg ? (33'd0 - magr) : magr;
        end
        unique case (in_data.fmt.enc)
            ENC_F32: v = {32'd0, in_data.clamped};
            ENC_F64: v = in_data.f64_bits;
            default: v = {32'd0, q[31:0]};
        endcase
        cnt_next = in_data.fmt.nbytes;
        st_next  = 1'b0;
        if (!in_data.fmt.supported) begin
            bytes_next = 64'd0;
            cnt_next   = 4'd0;
            st_next    = 1'b1;
        end else if (!in_data.fmt.big) begin
            unique case (in_data.fmt.nbytes)
                4'd2:    bytes_next = {48'd0, v[15:0]};
                4'd3:    bytes_next = {40'd0, v[23:0]};
                4'd4:    bytes_next = {32'd0, v[31:0]};
                default: bytes_next = v;
            endcase
        end else begin
            unique case (in_data.fmt.nbytes)
                4'd2:    bytes_next = {48'd0, v[7:0], v[15:8]};
                4'd3:    bytes_next = {40'd0, v[7:0], v[15:8], v[23:16]};
                4'd4:    bytes_next = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
                default: bytes_next = {v[7:0], v[15:8], v[23:16], v[31:24],
                                       v[39:32], v[47:40], v[55:48], v[63:56]};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
        if (in_ready && in_valid) begin
            bytes_reg <= bytes_next;
            cnt_reg   <= cnt_next;
            st_reg    <= st_next;
        end
    end
endmodule

// ===== design/float_to_pcm_sample_packer_top.sv =====
// Top level of the float32 to PCM sample packer.
//
// Usage:
//   Input channel s_valid/s_ready carries one float32 sample per beat in
//   s_sample_bits. Output channel m_valid/m_ready carries one encoded beat:
//   m_out_bytes (memory byte i in bits 8i+7..8i), m_sample_len and m_status.
//   cfg_we/cfg_wdata write the output format code; write it only while no
//   beat is in flight. Codes 18..31 give status 1 with zero bytes.
// Throughput: one beat per cycle while m_ready is high; three register
//   stages (decode/clamp, align/widen, round/pack) each hold one beat
//   with its own valid bit.
// Reset: aresetn low empties every stage and sets the format to int16
//   little-endian (code 9).
// Stall: when m_ready is low the output stage holds its beat; upstream
//   stages keep filling until each holds a beat, then s_ready drops. No
//   beat is lost or repeated.
`include "float_to_pcm_sample_packer_top_assert.svh"

module float_to_pcm_sample_packer_top
    import f2pcm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_sample_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_out_bytes,
    output logic [3:0]  m_sample_len,
    output logic        m_status
);
    logic [4:0] fmt_reg, fmt_next;
    logic       v1, r1, v2, r2;
    s1_t        d1;
    s2_t        d2;

    // Latch the format code on a write; hold otherwise.
    assign fmt_next = cfg_we ? cfg_wdata : fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= FMT_RESET;
        end else begin
            fmt_reg <= fmt_next;
        end
    end

    // Decode the format and clamp the sample.
    f2pcm_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_bits   (s_sample_bits),
        .fmt_code  (fmt_reg),
        .out_valid (v1),
        .out_ready (r1),
        .out_data  (d1)
    );

    // Align the magnitude for rounding and widen to float64.
    f2pcm_shift u_shift (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1),
        .in_ready  (r1),
        .in_data   (d1),
        .out_valid (v2),
        .out_ready (r2),
        .out_data  (d2)
    );

    // Round, saturate and order the bytes into the output register.
    f2pcm_pack u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (v2),
        .in_ready   (r2),
        .in_data    (d2),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_bytes  (m_out_bytes),
        .sample_len (m_sample_len),
        .status     (m_status)
    );

    `F2PCM_ASSERT(a_unsup_zero, m_valid && m_status |-> m_sample_len == 4'd0 && m_out_bytes == 64'd0, "unsupported beat not zeroed")
    `F2PCM_ASSERT(a_count_legal, m_valid && !m_status |-> m_sample_len == 4'd2 || m_sample_len == 4'd3 || m_sample_len == 4'd4 || m_sample_len == 4'd8, "illegal byte count")
    `F2PCM_ASSERT(a_upper_zero, m_valid && m_sample_len == 4'd2 |-> m_out_bytes[63:16] == 48'd0, "bytes above count not zero")
    `F2PCM_ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "output valid after reset")
endmodule
